### rtl/cls_pkg.sv
// Types and codes shared by the compacting list store.
package cls_pkg;

	localparam logic [2:0] FUNC_APPEND = 3'd0;
	localparam logic [2:0] FUNC_REMOVE = 3'd1;
	localparam logic [2:0] FUNC_FIND   = 3'd2;
	localparam logic [2:0] FUNC_READ   = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] value;
		logic [5:0]  slot;
	} cls_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] item_value;
		logic [5:0]  position;
		logic [6:0]  entry_count;
		logic        is_empty;
	} cls_out_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RDOUT = 4'b0010,
		ST_FIND  = 4'b0100,
		ST_SHIFT = 4'b1000
	} cls_state_t;

endpackage

### rtl/compacting_list_store.sv
// Compacting list store: ordered list with append, remove, find, read and clear.
// Append, clear, unused codes, out-of-range requests, find on an empty list and removing
// the last entry answer in the cycle after start; a read registers the word, then the result.
// Find scans entries in order; remove shifts later entries down a slot by the one port pair.
// busy is high while a read, find or remove runs; the next word is taken as its result is out.
// Reset clears the entry count and sequencer; stored entries are undefined until written.
module compacting_list_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cls_pkg::cls_in_t    cmd,
	output logic                busy,
	output logic                done,
	output cls_pkg::cls_out_t   result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ((CW > 7) ? CW : 7) + 1;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	cls_pkg::cls_state_t state_q, state_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [WIDTH-1:0] val_q, val_d;
	logic             done_q, done_d;
	cls_pkg::cls_out_t res_q, res_d;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [WIDTH-1:0] wdata;

	logic [1:0]       st_d;
	logic [WIDTH-1:0] rdv_d;
	logic [AW-1:0]    pos_d;

	logic [EW-1:0]    cnt_e, slot_e, slot_p1, idx_e, idx_p1, idx_p2;
	logic [EW-1:0]    cnt_de, pos_e;
	logic [63:0]      val_in64, rdv64;
	logic [WIDTH-1:0] val_in;

	assign cnt_e    = EW'(cnt_q);
	assign slot_e   = EW'(cmd.slot);
	assign slot_p1  = slot_e + EW'(1);
	assign idx_e    = EW'(idx_q);
	assign idx_p1   = idx_e + EW'(1);
	assign idx_p2   = idx_e + EW'(2);
	assign val_in64 = 64'(cmd.value);
	assign val_in   = val_in64[WIDTH-1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		val_d   = val_q;
		done_d  = 1'b0;
		we      = 1'b0;
		waddr   = idx_q;
		wdata   = rdata_q;
		raddr   = '0;
		st_d    = cls_pkg::STATUS_OK;
		rdv_d   = '0;
		pos_d   = '0;
		case (state_q)
			cls_pkg::ST_IDLE: begin
				if (start) begin
					case (cmd.func)
						cls_pkg::FUNC_APPEND: begin
							done_d = 1'b1;
							if (cnt_e == EW'(DEPTH)) begin
								st_d = cls_pkg::STATUS_FULL;
							end else begin
								we    = 1'b1;
								waddr = cnt_e[AW-1:0];
								wdata = val_in;
								cnt_d = cnt_q + CW'(1);
							end
						end
						cls_pkg::FUNC_REMOVE: begin
							if (slot_e >= cnt_e) begin
								done_d = 1'b1;
								st_d   = cls_pkg::STATUS_RANGE;
							end else if (slot_p1 >= cnt_e) begin
								done_d = 1'b1;
								cnt_d  = cnt_q - CW'(1);
							end else begin
								raddr   = slot_p1[AW-1:0];
								idx_d   = slot_e[AW-1:0];
								state_d = cls_pkg::ST_SHIFT;
							end
						end
						cls_pkg::FUNC_FIND: begin
							val_d = val_in;
							if (cnt_q == '0) begin
								done_d = 1'b1;
								st_d   = cls_pkg::STATUS_NOTFOUND;
							end else begin
								raddr   = '0;
								idx_d   = '0;
								state_d = cls_pkg::ST_FIND;
							end
						end
						cls_pkg::FUNC_READ: begin
							if (slot_e >= cnt_e) begin
								done_d = 1'b1;
								st_d   = cls_pkg::STATUS_RANGE;
							end else begin
								raddr   = slot_e[AW-1:0];
								state_d = cls_pkg::ST_RDOUT;
							end
						end
						cls_pkg::FUNC_CLEAR: begin
							done_d = 1'b1;
							cnt_d  = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			cls_pkg::ST_RDOUT: begin
				done_d  = 1'b1;
				rdv_d   = rdata_q;
				state_d = cls_pkg::ST_IDLE;
			end
			cls_pkg::ST_FIND: begin
				if (rdata_q == val_q) begin
					done_d  = 1'b1;
					pos_d   = idx_q;
					state_d = cls_pkg::ST_IDLE;
				end else if (idx_p1 >= cnt_e) begin
					done_d  = 1'b1;
					st_d    = cls_pkg::STATUS_NOTFOUND;
					state_d = cls_pkg::ST_IDLE;
				end else begin
					raddr = idx_p1[AW-1:0];
					idx_d = idx_p1[AW-1:0];
				end
			end
			cls_pkg::ST_SHIFT: begin
				we = 1'b1;
				if (idx_p2 >= cnt_e) begin
					done_d  = 1'b1;
					cnt_d   = cnt_q - CW'(1);
					state_d = cls_pkg::ST_IDLE;
				end else begin
					raddr = idx_p2[AW-1:0];
					idx_d = idx_p1[AW-1:0];
				end
			end
			default: begin
				state_d = cls_pkg::ST_IDLE;
			end
		endcase
	end

	assign cnt_de = EW'(cnt_d);
	assign pos_e  = EW'(pos_d);
	assign rdv64  = 64'(rdv_d);

	always_comb begin
		res_d.status      = st_d;
		res_d.item_value  = rdv64[31:0];
		res_d.position    = pos_e[5:0];
		res_d.entry_count = cnt_de[6:0];
		res_d.is_empty    = (cnt_d == '0);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cls_pkg::ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		val_q <= val_d;
		if (done_d) begin
			res_q <= res_d;
		end
	end

	assign busy   = (state_q != cls_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
